/* design/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Command codes, status codes and store control type shared by the
// double-ended queue and its word store.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  // fixed field widths on the stream ports
  localparam int unsigned CMD_BITS  = 3;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned STAT_BITS = 2;
  localparam int unsigned OCC_BITS  = 7;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // one access to the word store per cycle
  typedef struct packed {
    logic en;   // access this cycle
    logic wr;   // write when set, read otherwise
  } mem_ctl_t;

endpackage

`default_nettype wire

/* design/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of words in a ring store: push, pop or peek at either end,
// one result beat per command with read word, status and occupancy.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                          tuser
//  s_*      in   [31:0] push_value              [2:0] command
//  m_*      out  [31:0] read_value,             [1:0] status
//                [38:32] occupancy, rest zero
//
//  One command beat per cycle while no result beat is stalled; its result
//  beat appears in the next cycle. The word store has one port and a
//  registered read; pointers and count live in registers.
//  While a result beat is stalled the input is held off, so the store's
//  read register keeps the stalled result's word.
//  Reset empties the queue at the clock edge and holds off input; store not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] push_value
  input  wire  [2:0]  s_tuser,   // [2:0] command
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // [31:0] read_value, [38:32] occupancy
  output logic [1:0]  m_tuser    // [1:0] status
);
  import dq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // queue state
  logic [PW-1:0] front, front_next;
  logic [PW-1:0] back, back_next;
  logic [CW-1:0] count, count_next;

  // result register
  logic                out_read;
  logic                out_read_next;
  status_t             out_status, out_status_next;
  logic [OCC_BITS-1:0] out_occ;

  // store port
  mem_ctl_t             mem_ctl;
  logic [PW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  logic          accept;
  cmd_t          cmd;
  logic [PW-1:0] front_dn, front_up, back_dn, back_up;
  logic          full, empty;

  logic signed [WORD_BITS-1:0] rword;
  logic        [DATA_BITS-1:0] rd_ext;

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tuser);
  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);

  // ring pointer neighbors
  assign front_dn = (front == '0) ? LAST_IDX : front - 1'b1;
  assign front_up = (front == LAST_IDX) ? '0 : front + 1'b1;
  assign back_dn  = (back == '0) ? LAST_IDX : back - 1'b1;
  assign back_up  = (back == LAST_IDX) ? '0 : back + 1'b1;

  assign mem_wdata = WORD_BITS'($unsigned(s_tdata));

  // command decode and next state
  always_comb begin
    front_next      = front;
    back_next       = back;
    count_next      = count;
    out_read_next   = 1'b0;
    out_status_next = STAT_OK;
    mem_ctl         = '{en: 1'b0, wr: 1'b0};
    mem_addr        = front;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          out_status_next = STAT_FULL;
        end else begin
          mem_ctl    = '{en: accept, wr: 1'b1};
          mem_addr   = front_dn;
          front_next = front_dn;
          count_next = count + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          out_status_next = STAT_FULL;
        end else begin
          mem_ctl    = '{en: accept, wr: 1'b1};
          mem_addr   = back;
          back_next  = back_up;
          count_next = count + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          out_status_next = STAT_EMPTY;
        end else begin
          mem_ctl       = '{en: accept, wr: 1'b0};
          mem_addr      = front;
          out_read_next = 1'b1;
          front_next    = front_up;
          count_next    = count - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          out_status_next = STAT_EMPTY;
        end else begin
          mem_ctl       = '{en: accept, wr: 1'b0};
          mem_addr      = back_dn;
          out_read_next = 1'b1;
          back_next     = back_dn;
          count_next    = count - 1'b1;
        end
      end
      CMD_PEEK_FRONT: begin
        if (empty) begin
          out_status_next = STAT_EMPTY;
        end else begin
          mem_ctl       = '{en: accept, wr: 1'b0};
          mem_addr      = front;
          out_read_next = 1'b1;
        end
      end
      CMD_PEEK_BACK: begin
        if (empty) begin
          out_status_next = STAT_EMPTY;
        end else begin
          mem_ctl       = '{en: accept, wr: 1'b0};
          mem_addr      = back_dn;
          out_read_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  dq_store #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // pointers, count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      back     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        front <= front_next;
        back  <= back_next;
        count <= count_next;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_read   <= out_read_next;
      out_status <= out_status_next;
      out_occ    <= OCC_BITS'(count_next);
    end
  end

  // read word sign-extended to the port width
  assign rword  = $signed(mem_rdata);
  assign rd_ext = out_read ? DATA_BITS'(rword) : '0;

  assign m_tdata = {1'b0, out_occ, rd_ext};
  assign m_tuser = out_status;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("stored count above depth");

  a_ends_meet: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FULL_CNT) |-> front == back)
    else $error("pointers disagree with count at empty or full");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK))
      |=> (count == $past(count) && front == $past(front)
           && back == $past(back)))
    else $error("dropped push changed state");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (accept && empty && (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK))
      |=> (out_status == STAT_EMPTY && !out_read))
    else $error("pop on empty queue not flagged");

endmodule

`default_nettype wire

/* design/dq_store.sv */
// ----------------------------------------------------------------------------
// dq_store
// Single-port synchronous word store, one read or one write per cycle,
// read data registered and held until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_store #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire                     clk,
  input  dq_pkg::mem_ctl_t        ctl,
  input  wire [$clog2(DEPTH)-1:0] addr,
  input  wire [WORD_BITS-1:0]     wdata,
  output logic [WORD_BITS-1:0]    rdata
);
  import dq_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  // write or read at the shared address
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.wr) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire
